// ===== rtl/core/olc_pkg.sv =====
// Shared types, codes and widths for the ordered list with compaction.
package olc_pkg;

  // Default configuration
  localparam int ENTRY_WIDTH_DEF = 32;
  localparam int DEPTH_DEF       = 64;

  // Fixed port field widths
  localparam int ACTION_W = 2;
  localparam int POS_W    = 6;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Request actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND    = 2'd0,
    ACT_REMOVE    = 2'd1,
    ACT_OVERWRITE = 2'd2,
    ACT_READ      = 2'd3
  } action_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SHIFT,
    S_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;   // latch the input beat
    logic exec;     // check and perform the request
    logic capture;  // take read data into the result
    logic shift;    // run the compaction pass
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic    err;         // request rejected
    action_t act;         // latched action
    logic    shift_done;  // compaction pass finished
  } dp_stat_t;

endpackage

// ===== rtl/core/olc_ctrl.sv =====
// Request sequencer for the ordered list: handshakes and step ordering.
module olc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  olc_pkg::dp_stat_t stat,
  output olc_pkg::ctl_cmd_t cmd
);

  olc_pkg::state_t state_r;
  olc_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= olc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      olc_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = olc_pkg::S_EXEC;
        end
      end
      olc_pkg::S_EXEC: begin
        if (stat.err) begin
          state_nxt = olc_pkg::S_DONE;
        end else begin
          unique case (stat.act)
            olc_pkg::ACT_READ:      state_nxt = olc_pkg::S_READ;
            olc_pkg::ACT_REMOVE:    state_nxt = olc_pkg::S_SHIFT;
            olc_pkg::ACT_APPEND:    state_nxt = olc_pkg::S_DONE;
            olc_pkg::ACT_OVERWRITE: state_nxt = olc_pkg::S_DONE;
            default:                state_nxt = olc_pkg::S_DONE;
          endcase
        end
      end
      olc_pkg::S_READ: begin
        state_nxt = olc_pkg::S_DONE;
      end
      olc_pkg::S_SHIFT: begin
        if (stat.shift_done) begin
          state_nxt = olc_pkg::S_DONE;
        end
      end
      olc_pkg::S_DONE: begin
        if (!out_stall) begin
          state_nxt = olc_pkg::S_IDLE;
        end
      end
      default: state_nxt = olc_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd         = '0;
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    unique case (state_r)
      olc_pkg::S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      olc_pkg::S_EXEC:  cmd.exec    = 1'b1;
      olc_pkg::S_READ:  cmd.capture = 1'b1;
      olc_pkg::S_SHIFT: cmd.shift   = 1'b1;
      olc_pkg::S_DONE:  out_valid   = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/olc_datapath.sv =====
// Entry memory, count, request latch and compaction pipeline of the list.
module olc_datapath #(
  parameter int ENTRY_WIDTH = olc_pkg::ENTRY_WIDTH_DEF,
  parameter int DEPTH       = olc_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  olc_pkg::ctl_cmd_t            cmd,
  output olc_pkg::dp_stat_t            stat,
  input  logic [olc_pkg::ACTION_W-1:0] in_action,
  input  logic [olc_pkg::POS_W-1:0]    in_position,
  input  logic [olc_pkg::VAL_W-1:0]    in_entry_value,
  output logic [olc_pkg::STATUS_W-1:0] out_status,
  output logic [olc_pkg::VAL_W-1:0]    out_read_value,
  output logic [olc_pkg::COUNT_W-1:0]  out_entry_count
);

  localparam int IW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int EW  = ENTRY_WIDTH;
  localparam int VW  = olc_pkg::VAL_W;
  localparam int XW  = CW + olc_pkg::POS_W;
  localparam int OCW = olc_pkg::COUNT_W;

  // Storage
  logic [EW-1:0] mem [DEPTH];

  olc_pkg::action_t             req_act_r;
  logic [olc_pkg::POS_W-1:0]    req_pos_r;
  logic [EW-1:0]                req_val_r;
  logic [CW-1:0]                count_r;
  logic [CW-1:0]                src_r;
  logic                         wb_v_r;
  logic [IW-1:0]                wb_addr_r;
  logic [EW-1:0]                rdata_r;
  olc_pkg::status_t             res_status_r;
  logic [VW-1:0]                res_value_r;

  logic             range_err;
  logic             full_err;
  logic             err;
  olc_pkg::status_t exec_status;
  logic [IW-1:0]    pos_idx;
  logic [CW-1:0]    src_m1;
  logic             shift_rd;
  logic             rd_en;
  logic [IW-1:0]    raddr;
  logic             we;
  logic [IW-1:0]    waddr;
  logic [EW-1:0]    wdata;

  // Request checks
  assign range_err = XW'(req_pos_r) >= XW'(count_r);
  assign full_err  = count_r == CW'(DEPTH);
  assign err       = (req_act_r == olc_pkg::ACT_APPEND) ? full_err : range_err;
  assign pos_idx   = IW'(req_pos_r);

  always_comb begin
    if (!err) begin
      exec_status = olc_pkg::ST_OK;
    end else if (req_act_r == olc_pkg::ACT_APPEND) begin
      exec_status = olc_pkg::ST_FULL;
    end else begin
      exec_status = olc_pkg::ST_RANGE;
    end
  end

  // Compaction: read source src, write it back one place lower in the next cycle
  assign shift_rd = cmd.shift && (src_r <= count_r);
  assign src_m1   = src_r - CW'(1);

  assign rd_en = shift_rd || (cmd.exec && !err && req_act_r == olc_pkg::ACT_READ);
  assign raddr = cmd.shift ? src_r[IW-1:0] : pos_idx;

  // Write port select
  always_comb begin
    we    = 1'b0;
    waddr = wb_addr_r;
    wdata = rdata_r;
    priority if (cmd.exec && !err && req_act_r == olc_pkg::ACT_APPEND) begin
      we    = 1'b1;
      waddr = count_r[IW-1:0];
      wdata = req_val_r;
    end else if (cmd.exec && !err && req_act_r == olc_pkg::ACT_OVERWRITE) begin
      we    = 1'b1;
      waddr = pos_idx;
      wdata = req_val_r;
    end else if (wb_v_r) begin
      we    = 1'b1;
    end
  end

  // Memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  // Request latch and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_act_r <= olc_pkg::action_t'(in_action);
      req_pos_r <= in_position;
      req_val_r <= EW'(in_entry_value);
    end
    if (cmd.exec) begin
      res_status_r <= exec_status;
      res_value_r  <= '0;
      src_r        <= CW'(req_pos_r) + CW'(1);
    end else if (shift_rd) begin
      src_r <= src_r + CW'(1);
    end
    if (cmd.capture) begin
      res_value_r <= VW'(rdata_r);
    end
    if (shift_rd) begin
      wb_addr_r <= src_m1[IW-1:0];
    end
  end

  // Control state: count and write-back valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      wb_v_r  <= 1'b0;
    end else begin
      wb_v_r <= shift_rd;
      if (cmd.exec && !err) begin
        if (req_act_r == olc_pkg::ACT_APPEND) begin
          count_r <= count_r + CW'(1);
        end else if (req_act_r == olc_pkg::ACT_REMOVE) begin
          count_r <= count_r - CW'(1);
        end
      end
    end
  end

  // Status back to the controller
  assign stat.err        = err;
  assign stat.act        = req_act_r;
  assign stat.shift_done = !shift_rd && !wb_v_r;

  assign out_status      = res_status_r;
  assign out_read_value  = res_value_r;
  assign out_entry_count = OCW'(count_r);

endmodule

// ===== rtl/core/ordered_list_with_compaction.sv =====
// Top level of the ordered list with compaction.
//
// Usage: one request beat enters on in_* (in_action, in_position,
// in_entry_value) when in_valid is high and in_stall low. Each request
// gives exactly one result beat on out_* (out_status, out_read_value,
// out_entry_count), taken when out_valid is high and out_stall low.
// Requests are handled one at a time; in_stall stays high from the
// accepting edge until the result beat has been taken, and the next
// request is taken no earlier than the cycle after that.
// Append, overwrite and any rejected request go from the execute step
// straight to the result; a read adds a step that captures the read
// data; a remove adds the compaction pass that copies each later entry
// down one place per cycle, which for the last entry has nothing to copy.
// A result waiting under out_stall holds its payload, and no new request
// is taken until it leaves.
// Reset (rst_n low, synchronous) empties the list and returns to idle.
// Entry contents are not cleared; only entries below the count are read.
module ordered_list_with_compaction #(
  parameter int ENTRY_WIDTH = olc_pkg::ENTRY_WIDTH_DEF,
  parameter int DEPTH       = olc_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [olc_pkg::ACTION_W-1:0] in_action,
  input  logic [olc_pkg::POS_W-1:0]    in_position,
  input  logic [olc_pkg::VAL_W-1:0]    in_entry_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [olc_pkg::STATUS_W-1:0] out_status,
  output logic [olc_pkg::VAL_W-1:0]    out_read_value,
  output logic [olc_pkg::COUNT_W-1:0]  out_entry_count
);

  olc_pkg::ctl_cmd_t cmd;
  olc_pkg::dp_stat_t stat;

  // Sequencer
  olc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage and arithmetic
  olc_datapath #(
    .ENTRY_WIDTH (ENTRY_WIDTH),
    .DEPTH       (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (in_action),
    .in_position     (in_position),
    .in_entry_value  (in_entry_value),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_entry_count (out_entry_count)
  );

endmodule

// ===== rtl/core/olc_checker.sv =====
// Port-level assertions for the ordered list, bound to the top level.
module olc_checker #(
  parameter int DEPTH = olc_pkg::DEPTH_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [olc_pkg::STATUS_W-1:0] out_status,
  input logic [olc_pkg::VAL_W-1:0]    out_read_value,
  input logic [olc_pkg::COUNT_W-1:0]  out_entry_count
);

  localparam int OCW = olc_pkg::COUNT_W;

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_read_value) && $stable(out_entry_count))
    else $error("result beat changed under stall");

  // One request in flight: accepting a beat closes the input
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && !out_valid)
    else $error("input open right after an accepted beat");

  // Taking the result returns to idle
  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid && !in_stall)
    else $error("result repeated or block not idle after delivery");

  // A rejected request reads as zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != olc_pkg::ST_OK |-> out_read_value == '0)
    else $error("nonzero read value on a rejected request");

  // Full status only with the list at capacity
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == olc_pkg::ST_FULL |-> out_entry_count == OCW'(DEPTH))
    else $error("full status with list below capacity");

endmodule

bind ordered_list_with_compaction olc_checker #(.DEPTH(DEPTH)) u_olc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_read_value  (out_read_value),
  .out_entry_count (out_entry_count)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for the ordered list with compaction.
`timescale 1ns / 100ps

module testbench;

  localparam int ACTION_W    = olc_pkg::ACTION_W;
  localparam int POS_W       = olc_pkg::POS_W;
  localparam int VAL_W       = olc_pkg::VAL_W;
  localparam int STATUS_W    = olc_pkg::STATUS_W;
  localparam int COUNT_W     = olc_pkg::COUNT_W;
  localparam int LIST_DEPTH  = olc_pkg::DEPTH_DEF;
  localparam int ENTRY_W     = olc_pkg::ENTRY_WIDTH_DEF;
  localparam int RAND_ITEMS  = 1300;
  localparam int CALM_TAIL   = 150;
  localparam int STUCK_LIMIT = 4000;
  localparam int TAIL_CYCLES = LIST_DEPTH + 8;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} walk_mode_t;

  typedef struct {
    olc_pkg::action_t act;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    bit             hold;   // wait for every result before sending
    bit             quiet;  // no idling on either side
  } request_t;

  typedef struct {
    olc_pkg::status_t   st;
    logic [VAL_W-1:0]   rd;
    logic [COUNT_W-1:0] cnt;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [ACTION_W-1:0] in_action = '0;
  logic [POS_W-1:0] in_position = '0;
  logic [VAL_W-1:0] in_entry_value = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [VAL_W-1:0] out_read_value;
  logic [COUNT_W-1:0] out_entry_count;

  // Pending requests, expected answers and beat bookkeeping
  request_t request_queue[$];
  outcome_t answer_queue[$];
  request_t cur_req;
  int n_beats_in = 0;
  int n_beats_out = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit calm = 1'b0;
  int stuck_cycles = 0;
  int mismatches = 0;

  // Shadow copy of the list
  logic [ENTRY_W-1:0] shadow_list [LIST_DEPTH];
  int shadow_len = 0;

  // Tallies for the closing summary
  int act_seen [4];
  int n_range = 0;
  int n_full = 0;
  int peak_len = 0;

  // Planner's view of the count, used only to aim positions
  int plan_len = 0;

  ordered_list_with_compaction DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_position    (in_position),
    .in_entry_value (in_entry_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_entry_count(out_entry_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one request to the shadow list and return the answer it gives
  function automatic outcome_t apply_request(request_t r);
    outcome_t o;
    int p;
    p = int'(r.pos);
    o.st = olc_pkg::ST_OK;
    o.rd = '0;
    act_seen[r.act]++;
    if (r.act == olc_pkg::ACT_APPEND) begin
      if (shadow_len >= LIST_DEPTH) begin
        o.st = olc_pkg::ST_FULL;
        n_full++;
      end else begin
        shadow_list[shadow_len] = r.val[ENTRY_W-1:0];
        shadow_len++;
      end
    end else if (p >= shadow_len) begin
      o.st = olc_pkg::ST_RANGE;
      n_range++;
    end else if (r.act == olc_pkg::ACT_REMOVE) begin
      shadow_len--;
      for (int i = p; i < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
    end else if (r.act == olc_pkg::ACT_OVERWRITE) begin
      shadow_list[p] = r.val[ENTRY_W-1:0];
    end else begin
      o.rd = VAL_W'(shadow_list[p]);
    end
    if (shadow_len > peak_len) peak_len = shadow_len;
    o.cnt = COUNT_W'(shadow_len);
    return o;
  endfunction

  // Queue a request and track the count it leaves behind
  task automatic plan_request(olc_pkg::action_t act, int pos, logic [VAL_W-1:0] val,
                              bit hold, bit quiet);
    request_t r;
    r.act = act;
    r.pos = POS_W'(pos);
    r.val = val;
    r.hold = hold;
    r.quiet = quiet;
    request_queue.push_back(r);
    if (act == olc_pkg::ACT_APPEND) begin
      if (plan_len < LIST_DEPTH) plan_len++;
    end else if (act == olc_pkg::ACT_REMOVE && int'(r.pos) < plan_len) begin
      plan_len--;
    end
  endtask

  // Position mostly inside the list, sometimes on its edge or anywhere
  function automatic int pick_position();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 5 && plan_len > 0) return $urandom_range(0, plan_len - 1);
    if (r == 6) return 0;
    if (r == 7) return plan_len % 64;
    if (r == 8 && plan_len > 0) return plan_len - 1;
    return $urandom_range(0, 63);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic olc_pkg::action_t pick_action(walk_mode_t mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (r < 70) return olc_pkg::ACT_APPEND;
      end
      MODE_DRAIN: begin
        if (r < 55) return olc_pkg::ACT_REMOVE;
        if (r < 70) return olc_pkg::ACT_APPEND;
      end
      default: begin
      end
    endcase
    return olc_pkg::action_t'($urandom_range(0, 3));
  endfunction

  // Stimulus plan, reset and end of run
  initial begin
    walk_mode_t mode;
    int block_len;
    int planned;
    bit quiet_block;

    // Directed: empty list, edges of position and value, shifts
    plan_request(olc_pkg::ACT_READ, 0, '0, 1'b0, 1'b0);
    plan_request(olc_pkg::ACT_REMOVE, 0, '1, 1'b0, 1'b0);
    plan_request(olc_pkg::ACT_OVERWRITE, 0, 32'h1234_5678, 1'b0, 1'b0);
    plan_request(olc_pkg::ACT_APPEND, 63, '0, 1'b0, 1'b0);
    plan_request(olc_pkg::ACT_APPEND, 0, '1, 1'b0, 1'b0);
    plan_request(olc_pkg::ACT_APPEND, 21, 32'hA5A5_A5A5, 1'b0, 1'b0);
    plan_request(olc_pkg::ACT_READ, 0, '1, 1'b0, 1'b0);
    plan_request(olc_pkg::ACT_READ, 1, '0, 1'b0, 1'b0);
    plan_request(olc_pkg::ACT_READ, 2, 32'h5555_5555, 1'b0, 1'b0);
    plan_request(olc_pkg::ACT_READ, 3, '0, 1'b0, 1'b0);
    plan_request(olc_pkg::ACT_OVERWRITE, 1, 32'h5A5A_5A5A, 1'b0, 1'b0);
    plan_request(olc_pkg::ACT_READ, 1, '0, 1'b0, 1'b0);
    plan_request(olc_pkg::ACT_READ, 63, '0, 1'b0, 1'b0);
    plan_request(olc_pkg::ACT_REMOVE, 63, '0, 1'b0, 1'b0);
    plan_request(olc_pkg::ACT_OVERWRITE, 63, '1, 1'b0, 1'b0);
    plan_request(olc_pkg::ACT_REMOVE, 0, '0, 1'b0, 1'b0);
    plan_request(olc_pkg::ACT_READ, 0, '0, 1'b0, 1'b0);
    plan_request(olc_pkg::ACT_READ, 1, '0, 1'b0, 1'b0);
    plan_request(olc_pkg::ACT_REMOVE, 1, '0, 1'b0, 1'b0);
    plan_request(olc_pkg::ACT_READ, 0, '0, 1'b0, 1'b0);
    plan_request(olc_pkg::ACT_REMOVE, 0, '0, 1'b0, 1'b0);
    plan_request(olc_pkg::ACT_READ, 0, '0, 1'b0, 1'b0);
    plan_request(olc_pkg::ACT_APPEND, 0, 32'hC0DE_0001, 1'b0, 1'b0);

    // Random walks; the first one fills the list past full
    planned = 0;
    mode = MODE_FILL;
    while (planned < RAND_ITEMS) begin
      block_len = (planned == 0) ? 140 : $urandom_range(30, 120);
      quiet_block = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < block_len && planned < RAND_ITEMS; k++) begin
        plan_request(pick_action(mode), pick_position(), pick_value(),
                     (k == 0) && (planned == 0 || $urandom_range(0, 3) == 0),
                     quiet_block || (planned >= RAND_ITEMS - CALM_TAIL));
        planned++;
      end
      mode = walk_mode_t'($urandom_range(0, 2));
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (!(request_queue.size() == 0 && !in_valid && n_beats_in == n_beats_out)
           && stuck_cycles < STUCK_LIMIT)
      @(posedge clk);

    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", STUCK_LIMIT);
      $display("Mismatches found");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
      // Every request must have been taken and answered
      if (in_valid || request_queue.size() != 0 || answer_queue.size() != 0 ||
          n_beats_in != n_beats_out) begin
        $error("result beats: expected %0d, got %0d",
               n_beats_in + request_queue.size() + int'(in_valid), n_beats_out);
        mismatches++;
      end
      $display("Ran %0d requests: %0d append, %0d remove, %0d overwrite, %0d read",
               n_beats_in, act_seen[olc_pkg::ACT_APPEND], act_seen[olc_pkg::ACT_REMOVE],
               act_seen[olc_pkg::ACT_OVERWRITE], act_seen[olc_pkg::ACT_READ]);
      $display("Rejected %0d out of range and %0d on a full list; peak count %0d",
               n_range, n_full, peak_len);
      if (mismatches == 0) begin
        $display("No mismatches found");
      end else begin
        $display("Mismatches found");
      end
    end
    $finish;
  end

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        answer_queue.push_back(apply_request(cur_req));
        n_beats_in <= n_beats_in + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (request_queue.size() == 0 ||
                     (request_queue[0].hold &&
                      (n_beats_in + int'(in_valid && !in_stall) !=
                       n_beats_out + int'(out_valid && !out_stall)))) begin
          in_valid <= 1'b0;
        end else begin
          cur_req = request_queue.pop_front();
          in_valid <= 1'b1;
          in_action <= cur_req.act;
          in_position <= cur_req.pos;
          in_entry_value <= cur_req.val;
          calm <= cur_req.quiet;
          if (!cur_req.quiet && $urandom_range(0, 5) == 0)
            gap_left <= $urandom_range(1, 15);
        end
      end
    end
  end

  // Result monitor and stall bursts
  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_beats_out <= n_beats_out + 1;
        if (answer_queue.size() == 0) begin
          $error("result beat with no request outstanding");
          mismatches++;
        end else begin
          want = answer_queue.pop_front();
          if (out_status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, out_status);
            mismatches++;
          end
          if (out_read_value !== want.rd) begin
            $error("read_value: expected %08h, got %08h", want.rd, out_read_value);
            mismatches++;
          end
          if (out_entry_count !== want.cnt) begin
            $error("entry_count: expected %0d, got %0d", want.cnt, out_entry_count);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 14);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

endmodule
